>>> rtl/gbyi_pkg.sv
package gbyi_pkg;

   // Raw sample format
   localparam int SAMPLE_WIDTH = 16;
   localparam int RAW_WIDTH = 16;
   localparam int SAMPLE_EFF_WIDTH = (SAMPLE_WIDTH > RAW_WIDTH) ? RAW_WIDTH : SAMPLE_WIDTH;
   localparam int SAMPLE_SHIFT = RAW_WIDTH - SAMPLE_EFF_WIDTH;

   // Calibration
   localparam int CALIB_WIDTH = 4;
   localparam int MAX_CALIB_LOG2 = 12;
   localparam int COUNT_WIDTH = MAX_CALIB_LOG2 + 1;
   localparam int BIAS_SUM_WIDTH = RAW_WIDTH + MAX_CALIB_LOG2 + 1;

   // Rate and gain
   localparam int RATE_WIDTH = RAW_WIDTH + 1;
   localparam int GAIN_WIDTH = 24;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int PROD_WIDTH = RATE_WIDTH + GAIN_WIDTH + 1;
   localparam int INC_WIDTH = PROD_WIDTH - GAIN_FRAC_BITS;

   // Angle accumulator
   localparam int ANGLE_WIDTH = 32;
   localparam int YAW_WIDTH = 32;
   localparam int SUM_WIDTH = (ANGLE_WIDTH > INC_WIDTH) ? ANGLE_WIDTH : INC_WIDTH;
   localparam int YAW_EXT_WIDTH = (ANGLE_WIDTH > YAW_WIDTH) ? ANGLE_WIDTH : YAW_WIDTH;

   // Register port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = GAIN_WIDTH;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CALIB_LOG2 = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_GAIN = 1'b1;
   localparam logic [CALIB_WIDTH-1:0] CALIB_LOG2_RESET = 4'd10;
   localparam logic [GAIN_WIDTH-1:0] ANGLE_GAIN_RESET = 24'd186414;

   typedef struct packed {
      logic calibrating;
      logic signed [RATE_WIDTH-1:0] rate;
   } rate_stage_type;

   typedef struct packed {
      logic calibrating;
      logic signed [RATE_WIDTH-1:0] rate;
      logic signed [PROD_WIDTH-1:0] product;
   } prod_stage_type;

endpackage

>>> rtl/gbyi_channels.sv
interface gbyi_req_if;
   logic valid;
   logic ready;
   logic [7:0] rate_low_byte;
   logic [7:0] rate_high_byte;

   modport source(output valid, output rate_low_byte, output rate_high_byte, input ready);
   modport sink(input valid, input rate_low_byte, input rate_high_byte, output ready);
endinterface

interface gbyi_rsp_if;
   logic valid;
   logic ready;
   logic signed [gbyi_pkg::YAW_WIDTH-1:0] heading;
   logic signed [gbyi_pkg::RATE_WIDTH-1:0] yaw_rate;
   logic calibrating;

   modport source(output valid, output heading, output yaw_rate, output calibrating,
                  input ready);
   modport sink(input valid, input heading, input yaw_rate, input calibrating,
                output ready);
endinterface

>>> rtl/gbyi_front.sv
module gbyi_front (
   input  logic clock,
   input  logic reset,
   input  logic [gbyi_pkg::CALIB_WIDTH-1:0] calib_log2,
   gbyi_req_if.sink req,
   input  logic down_ready,
   output logic stage_valid,
   output gbyi_pkg::rate_stage_type stage
);

   logic [gbyi_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic signed [gbyi_pkg::BIAS_SUM_WIDTH-1:0] bias_sum_ff, bias_sum_in;
   logic stage_valid_ff, stage_valid_in;
   gbyi_pkg::rate_stage_type stage_ff, stage_in;

   logic [gbyi_pkg::CALIB_WIDTH-1:0] shift_k;
   logic [gbyi_pkg::COUNT_WIDTH-1:0] need;
   logic [gbyi_pkg::RAW_WIDTH-1:0] word;
   logic signed [gbyi_pkg::RAW_WIDTH-1:0] raw;
   logic signed [gbyi_pkg::BIAS_SUM_WIDTH-1:0] shifted;
   logic [gbyi_pkg::BIAS_SUM_WIDTH-gbyi_pkg::RAW_WIDTH:0] upper;
   logic signed [gbyi_pkg::RAW_WIDTH-1:0] bias;
   logic calib_now;
   logic accept;

   // Effective shift, clamped to the largest supported window
   assign shift_k = (calib_log2 > gbyi_pkg::CALIB_WIDTH'(gbyi_pkg::MAX_CALIB_LOG2))
                    ? gbyi_pkg::CALIB_WIDTH'(gbyi_pkg::MAX_CALIB_LOG2) : calib_log2;
   assign need = gbyi_pkg::COUNT_WIDTH'(1) << shift_k;
   assign calib_now = count_ff < need;

   // Raw sample, sign-extended from its effective width
   assign word = {req.rate_high_byte, req.rate_low_byte};
   assign raw = $signed(word << gbyi_pkg::SAMPLE_SHIFT) >>> gbyi_pkg::SAMPLE_SHIFT;

   // Floored mean of the sum, saturated to the sample range
   assign shifted = bias_sum_ff >>> shift_k;
   assign upper = shifted[gbyi_pkg::BIAS_SUM_WIDTH-1:gbyi_pkg::RAW_WIDTH-1];
   always_comb begin
      if ((&upper) || !(|upper)) begin
         bias = shifted[gbyi_pkg::RAW_WIDTH-1:0];
      end else begin
         bias = {shifted[gbyi_pkg::BIAS_SUM_WIDTH-1],
                 {(gbyi_pkg::RAW_WIDTH-1){~shifted[gbyi_pkg::BIAS_SUM_WIDTH-1]}}};
      end
   end

   assign req.ready = !stage_valid_ff || down_ready;
   assign accept = req.valid && req.ready;

   // Calibration state and stage register next values
   always_comb begin
      count_in = count_ff;
      bias_sum_in = bias_sum_ff;
      stage_in = stage_ff;
      stage_valid_in = stage_valid_ff && !down_ready;
      if (accept) begin
         stage_valid_in = 1'b1;
         stage_in.calibrating = calib_now;
         if (calib_now) begin
            count_in = count_ff + gbyi_pkg::COUNT_WIDTH'(1);
            bias_sum_in = bias_sum_ff + gbyi_pkg::BIAS_SUM_WIDTH'(raw);
            stage_in.rate = '0;
         end else begin
            stage_in.rate = gbyi_pkg::RATE_WIDTH'(bias) - gbyi_pkg::RATE_WIDTH'(raw);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bias_sum_ff <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         bias_sum_ff <= bias_sum_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_valid = stage_valid_ff;
   assign stage = stage_ff;

endmodule

>>> rtl/gbyi_scale.sv
module gbyi_scale (
   input  logic clock,
   input  logic reset,
   input  logic [gbyi_pkg::GAIN_WIDTH-1:0] angle_gain,
   input  logic up_valid,
   input  gbyi_pkg::rate_stage_type up_stage,
   output logic up_ready,
   input  logic down_ready,
   output logic stage_valid,
   output gbyi_pkg::prod_stage_type stage
);

   logic stage_valid_ff, stage_valid_in;
   gbyi_pkg::prod_stage_type stage_ff, stage_in;
   logic load;

   assign up_ready = !stage_valid_ff || down_ready;
   assign load = up_valid && up_ready;

   // Rate times Q8 gain, registered
   always_comb begin
      stage_in = stage_ff;
      stage_valid_in = stage_valid_ff && !down_ready;
      if (load) begin
         stage_valid_in = 1'b1;
         stage_in.calibrating = up_stage.calibrating;
         stage_in.rate = up_stage.rate;
         stage_in.product = gbyi_pkg::PROD_WIDTH'(up_stage.rate) *
                            gbyi_pkg::PROD_WIDTH'($signed({1'b0, angle_gain}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_valid = stage_valid_ff;
   assign stage = stage_ff;

endmodule

>>> rtl/gbyi_accum.sv
module gbyi_accum (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   input  gbyi_pkg::prod_stage_type up_stage,
   output logic up_ready,
   gbyi_rsp_if.source rsp
);

   logic [gbyi_pkg::ANGLE_WIDTH-1:0] acc_ff, acc_in;
   logic out_valid_ff, out_valid_in;
   logic signed [gbyi_pkg::YAW_WIDTH-1:0] heading_ff, heading_in;
   logic signed [gbyi_pkg::RATE_WIDTH-1:0] yaw_rate_ff, yaw_rate_in;
   logic calibrating_ff, calibrating_in;

   logic signed [gbyi_pkg::INC_WIDTH-1:0] inc;
   logic [gbyi_pkg::SUM_WIDTH-1:0] sum;
   logic [gbyi_pkg::ANGLE_WIDTH-1:0] acc_next;
   logic signed [gbyi_pkg::YAW_EXT_WIDTH-1:0] yaw_ext;
   logic load;

   assign up_ready = !out_valid_ff || rsp.ready;
   assign load = up_valid && up_ready;

   // Floored increment, wrapping add into the angle
   assign inc = $signed(up_stage.product[gbyi_pkg::PROD_WIDTH-1:gbyi_pkg::GAIN_FRAC_BITS]);
   assign sum = gbyi_pkg::SUM_WIDTH'(acc_ff) + gbyi_pkg::SUM_WIDTH'(inc);
   assign acc_next = sum[gbyi_pkg::ANGLE_WIDTH-1:0];
   assign yaw_ext = gbyi_pkg::YAW_EXT_WIDTH'($signed(acc_next));

   always_comb begin
      acc_in = acc_ff;
      heading_in = heading_ff;
      yaw_rate_in = yaw_rate_ff;
      calibrating_in = calibrating_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (load) begin
         out_valid_in = 1'b1;
         calibrating_in = up_stage.calibrating;
         if (up_stage.calibrating) begin
            heading_in = '0;
            yaw_rate_in = '0;
         end else begin
            acc_in = acc_next;
            heading_in = yaw_ext[gbyi_pkg::YAW_WIDTH-1:0];
            yaw_rate_in = up_stage.rate;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      heading_ff <= heading_in;
      yaw_rate_ff <= yaw_rate_in;
      calibrating_ff <= calibrating_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.heading = heading_ff;
   assign rsp.yaw_rate = yaw_rate_ff;
   assign rsp.calibrating = calibrating_ff;

endmodule

>>> rtl/gyro_bias_yaw_integrator.sv
// Gyro bias calibration and yaw integration.
// Three register stages (intake/bias, multiply, accumulate); the result is held on rsp_chan
// until taken. Throughput: one item per cycle unless rsp_chan stalls; each stage takes a new
// item as soon as its register frees.
// Reset (synchronous, active high) clears the pipeline, sample count, bias sum and angle,
// and loads calib_log2 = 10 and angle_gain = 186414.
module gyro_bias_yaw_integrator (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [gbyi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [gbyi_pkg::CSR_DATA_WIDTH-1:0] csr_write_data,
   gbyi_req_if.sink req_chan,
   gbyi_rsp_if.source rsp_chan
);

   logic [gbyi_pkg::CALIB_WIDTH-1:0] calib_log2_ff, calib_log2_in;
   logic [gbyi_pkg::GAIN_WIDTH-1:0] angle_gain_ff, angle_gain_in;

   logic s1_valid, s2_valid, s1_ready, s2_ready;
   gbyi_pkg::rate_stage_type s1_stage;
   gbyi_pkg::prod_stage_type s2_stage;

   // Configuration registers
   always_comb begin
      calib_log2_in = calib_log2_ff;
      angle_gain_in = angle_gain_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            gbyi_pkg::CSR_CALIB_LOG2: calib_log2_in = csr_write_data[gbyi_pkg::CALIB_WIDTH-1:0];
            gbyi_pkg::CSR_ANGLE_GAIN: angle_gain_in = csr_write_data[gbyi_pkg::GAIN_WIDTH-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_log2_ff <= gbyi_pkg::CALIB_LOG2_RESET;
         angle_gain_ff <= gbyi_pkg::ANGLE_GAIN_RESET;
      end else begin
         calib_log2_ff <= calib_log2_in;
         angle_gain_ff <= angle_gain_in;
      end
   end

   gbyi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .calib_log2  (calib_log2_ff),
      .req         (req_chan),
      .down_ready  (s1_ready),
      .stage_valid (s1_valid),
      .stage       (s1_stage)
   );

   gbyi_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .angle_gain  (angle_gain_ff),
      .up_valid    (s1_valid),
      .up_stage    (s1_stage),
      .up_ready    (s1_ready),
      .down_ready  (s2_ready),
      .stage_valid (s2_valid),
      .stage       (s2_stage)
   );

   gbyi_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid),
      .up_stage (s2_stage),
      .up_ready (s2_ready),
      .rsp      (rsp_chan)
   );

`ifndef ASSERT_OFF
   // A calibrating result carries zero rate and zero angle
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.calibrating |-> rsp_chan.yaw_rate == '0 &&
                                                 rsp_chan.heading == '0)
      else $error("calibrating result with nonzero payload");

   // An accepted item always lands in the intake stage
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> s1_valid)
      else $error("accepted item lost at intake");

   // A full multiply stage that cannot move blocks the intake stage
   assert property (@(posedge clock) disable iff (reset)
      s2_valid && !s2_ready |-> !s1_ready)
      else $error("intake stage ready while multiply stage stalled");

   // Reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !s1_valid && !s2_valid)
      else $error("pipeline not empty after reset");
`endif

endmodule
